// ----- rtl/tsq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-stack queue package
// Shared payload types, operation and status codes, and the control word and
// flag bundles that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package tsq_pkg;

	// Operation codes carried by an input item.
	localparam logic [1:0] OP_ENQ  = 2'd0;
	localparam logic [1:0] OP_DEQ  = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;
	localparam logic [1:0] OP_NOP  = 2'd3;

	// Status codes carried by a result item.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	// Capacity register width and reset value.
	localparam int         CAP_W     = 5;
	localparam logic [4:0] CAP_RESET = 5'd16;

	// Microcode step address width.
	localparam int STEP_W = 4;

	// Branch condition codes of the control word.
	localparam logic [2:0] C_ALWAYS    = 3'd0;
	localparam logic [2:0] C_ACCEPT    = 3'd1;
	localparam logic [2:0] C_DISPATCH  = 3'd2;
	localparam logic [2:0] C_FULL      = 3'd3;
	localparam logic [2:0] C_EMPTY     = 3'd4;
	localparam logic [2:0] C_OUT_NZ    = 3'd5;
	localparam logic [2:0] C_IN_MORE   = 3'd6;
	localparam logic [2:0] C_SLOT_FREE = 3'd7;

	// Input item.
	typedef struct packed {
		logic        [1:0]  opcode;
		logic signed [31:0] push_value;
	} cmd_t;

	// Result item.
	typedef struct packed {
		logic        [1:0]  status;
		logic signed [31:0] read_value;
	} rsp_t;

	// One microcode word: branch control plus datapath actions.
	typedef struct packed {
		logic [2:0]        cond;
		logic [STEP_W-1:0] target_t;
		logic [STEP_W-1:0] target_f;
		logic              take;
		logic              push;
		logic              move;
		logic              pop_rd;
		logic              emit;
		logic [1:0]        status;
		logic              sel_rd;
	} ctl_t;

	// Datapath conditions sampled by the sequencer.
	typedef struct packed {
		logic       accept;
		logic [1:0] opcode;
		logic       full;
		logic       empty;
		logic       out_nz;
		logic       in_more;
		logic       slot_free;
	} flags_t;

endpackage

// ----- rtl/two_stack_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-stack queue core
// First-in first-out queue built from an input stack and an output stack,
// controlled by a small microcoded sequencer.
//
//   Channel   Direction  Handshake             Payload
//   cmd       in         cmd_valid/cmd_stall   cmd_t: opcode, push_value
//   rsp       out        rsp_valid/rsp_stall   rsp_t: status, read_value
//   cfg       in         cfg_valid/cfg_ready   cfg_data: queue capacity
//
// One item at a time. A dequeue or peek with an empty output stack first
// transfers every entry of the input stack (at most DEPTH) to the output
// stack: the transfer moves one entry per cycle through the single read port
// of the input stack memory.
// Reset clears both counters and the capacity to 16; no clearing pass.
// A stalled result sits in the output register; the next item is taken once
// that result is in the register, and it waits only at its own result step.
// ----------------------------------------------------------------------------
module two_stack_queue_core import tsq_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  cmd_t             cmd,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data
);

	logic [CAP_W-1:0] cap_q;
	ctl_t             ctl;
	flags_t           flags;

	// Capacity register: writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// Control program.
	tsq_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl)
	);

	// Stacks, counters and result register.
	tsq_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.flags     (flags),
		.capacity  (cap_q),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ----- rtl/tsq_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-stack queue sequencer
// Step counter and control store. Each step reads one control word that
// drives the datapath and selects the next step from a datapath flag.
// ----------------------------------------------------------------------------
module tsq_sequencer import tsq_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  flags_t flags,
	output ctl_t   ctl
);

	// Step addresses of the program.
	localparam logic [STEP_W-1:0] S_FETCH     = 4'd0;
	localparam logic [STEP_W-1:0] S_DECODE    = 4'd1;
	localparam logic [STEP_W-1:0] S_ENQ_CHK   = 4'd2;
	localparam logic [STEP_W-1:0] S_ENQ_PUSH  = 4'd3;
	localparam logic [STEP_W-1:0] S_DQ_CHK    = 4'd4;
	localparam logic [STEP_W-1:0] S_REF_CHK   = 4'd5;
	localparam logic [STEP_W-1:0] S_MOVE      = 4'd6;
	localparam logic [STEP_W-1:0] S_FLUSH     = 4'd7;
	localparam logic [STEP_W-1:0] S_READ_TOP  = 4'd8;
	localparam logic [STEP_W-1:0] S_EMIT_DATA = 4'd9;
	localparam logic [STEP_W-1:0] S_EMIT_OK   = 4'd10;
	localparam logic [STEP_W-1:0] S_EMIT_OVF  = 4'd11;
	localparam logic [STEP_W-1:0] S_EMIT_UNF  = 4'd12;

	// Builds one control word.
	function automatic ctl_t mk(
		input logic [2:0]        cond,
		input logic [STEP_W-1:0] t,
		input logic [STEP_W-1:0] f,
		input logic              take,
		input logic              push,
		input logic              move,
		input logic              pop_rd,
		input logic              emit,
		input logic [1:0]        status,
		input logic              sel_rd
	);
		ctl_t w;
		w.cond     = cond;
		w.target_t = t;
		w.target_f = f;
		w.take     = take;
		w.push     = push;
		w.move     = move;
		w.pop_rd   = pop_rd;
		w.emit     = emit;
		w.status   = status;
		w.sel_rd   = sel_rd;
		return w;
	endfunction

	// Control store.
	function automatic ctl_t rom(input logic [STEP_W-1:0] a);
		ctl_t w;
		case (a)
			S_FETCH:     w = mk(C_ACCEPT, S_DECODE, S_FETCH, 1'b1, 1'b0, 1'b0, 1'b0,
				1'b0, ST_OK, 1'b0);
			S_DECODE:    w = mk(C_DISPATCH, S_FETCH, S_FETCH, 1'b0, 1'b0, 1'b0, 1'b0,
				1'b0, ST_OK, 1'b0);
			S_ENQ_CHK:   w = mk(C_FULL, S_EMIT_OVF, S_ENQ_PUSH, 1'b0, 1'b0, 1'b0, 1'b0,
				1'b0, ST_OK, 1'b0);
			S_ENQ_PUSH:  w = mk(C_ALWAYS, S_EMIT_OK, S_EMIT_OK, 1'b0, 1'b1, 1'b0, 1'b0,
				1'b0, ST_OK, 1'b0);
			S_DQ_CHK:    w = mk(C_EMPTY, S_EMIT_UNF, S_REF_CHK, 1'b0, 1'b0, 1'b0, 1'b0,
				1'b0, ST_OK, 1'b0);
			S_REF_CHK:   w = mk(C_OUT_NZ, S_READ_TOP, S_MOVE, 1'b0, 1'b0, 1'b0, 1'b0,
				1'b0, ST_OK, 1'b0);
			S_MOVE:      w = mk(C_IN_MORE, S_MOVE, S_FLUSH, 1'b0, 1'b0, 1'b1, 1'b0,
				1'b0, ST_OK, 1'b0);
			S_FLUSH:     w = mk(C_ALWAYS, S_READ_TOP, S_READ_TOP, 1'b0, 1'b0, 1'b0, 1'b0,
				1'b0, ST_OK, 1'b0);
			S_READ_TOP:  w = mk(C_ALWAYS, S_EMIT_DATA, S_EMIT_DATA, 1'b0, 1'b0, 1'b0, 1'b1,
				1'b0, ST_OK, 1'b0);
			S_EMIT_DATA: w = mk(C_SLOT_FREE, S_FETCH, S_EMIT_DATA, 1'b0, 1'b0, 1'b0, 1'b0,
				1'b1, ST_OK, 1'b1);
			S_EMIT_OK:   w = mk(C_SLOT_FREE, S_FETCH, S_EMIT_OK, 1'b0, 1'b0, 1'b0, 1'b0,
				1'b1, ST_OK, 1'b0);
			S_EMIT_OVF:  w = mk(C_SLOT_FREE, S_FETCH, S_EMIT_OVF, 1'b0, 1'b0, 1'b0, 1'b0,
				1'b1, ST_OVERFLOW, 1'b0);
			S_EMIT_UNF:  w = mk(C_SLOT_FREE, S_FETCH, S_EMIT_UNF, 1'b0, 1'b0, 1'b0, 1'b0,
				1'b1, ST_UNDERFLOW, 1'b0);
			default:     w = mk(C_ALWAYS, S_FETCH, S_FETCH, 1'b0, 1'b0, 1'b0, 1'b0,
				1'b0, ST_OK, 1'b0);
		endcase
		return w;
	endfunction

	// Entry step for each operation.
	function automatic logic [STEP_W-1:0] op_entry(input logic [1:0] op);
		logic [STEP_W-1:0] s;
		if (op == OP_ENQ) begin
			s = S_ENQ_CHK;
		end else if (op inside {OP_DEQ, OP_PEEK}) begin
			s = S_DQ_CHK;
		end else begin
			s = S_EMIT_OK;
		end
		return s;
	endfunction

	logic [STEP_W-1:0] upc_q;
	logic [STEP_W-1:0] upc_next;
	logic              taken;

	assign ctl = rom(upc_q);

	// Branch condition select.
	always_comb begin
		case (ctl.cond)
			C_ALWAYS:    taken = 1'b1;
			C_ACCEPT:    taken = flags.accept;
			C_FULL:      taken = flags.full;
			C_EMPTY:     taken = flags.empty;
			C_OUT_NZ:    taken = flags.out_nz;
			C_IN_MORE:   taken = flags.in_more;
			C_SLOT_FREE: taken = flags.slot_free;
			default:     taken = 1'b0;
		endcase
		if (ctl.cond == C_DISPATCH) begin
			upc_next = op_entry(flags.opcode);
		end else begin
			upc_next = taken ? ctl.target_t : ctl.target_f;
		end
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_FETCH;
		end else begin
			upc_q <= upc_next;
		end
	end

endmodule

// ----- rtl/tsq_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-stack queue datapath
// Input and output stack memories, their counters, the latched item and the
// result register, all driven by the sequencer's control word.
// ----------------------------------------------------------------------------
module tsq_datapath import tsq_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_t             ctl,
	output flags_t           flags,
	input  logic [CAP_W-1:0] capacity,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  cmd_t             cmd,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp
);

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CMP_W  = (CNT_W + 1 > CAP_W) ? CNT_W + 1 : CAP_W;

	logic [1:0]            op_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [DATA_WIDTH-1:0] val_ext;
	logic [CNT_W-1:0]      in_cnt_q;
	logic [CNT_W-1:0]      out_cnt_q;
	logic                  mv_pend_q;
	logic [DATA_WIDTH-1:0] in_rd_q;
	logic [DATA_WIDTH-1:0] out_rd_q;
	logic [DATA_WIDTH-1:0] in_mem  [DEPTH];
	logic [DATA_WIDTH-1:0] out_mem [DEPTH];
	logic [ADDR_W-1:0]     in_top;
	logic [ADDR_W-1:0]     out_top;
	logic [CNT_W-1:0]      in_dec;
	logic [CNT_W-1:0]      out_dec;
	logic [CMP_W-1:0]      cap_ext;
	logic [CMP_W-1:0]      eff_cap;
	logic [CMP_W-1:0]      fill;
	logic [31:0]           rd_trim;
	logic                  accept;
	logic                  slot_free;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	// Input handshake: items are taken only at the fetch step.
	assign cmd_stall = !ctl.take;
	assign accept    = ctl.take && cmd_valid;

	// Sign extension or truncation of the pushed value, and trimming or zero extension of the read value.
	generate
		if (DATA_WIDTH >= 32) begin : g_wide
			assign val_ext = DATA_WIDTH'($signed(cmd.push_value));
			assign rd_trim = out_rd_q[31:0];
		end else begin : g_narrow
			assign val_ext = cmd.push_value[DATA_WIDTH-1:0];
			assign rd_trim = 32'(out_rd_q);
		end
	endgenerate

	// Latched item.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= cmd.opcode;
			val_q <= val_ext;
		end
	end

	// Stack pointers and fill compare.
	assign in_dec  = in_cnt_q - CNT_W'(1);
	assign out_dec = out_cnt_q - CNT_W'(1);
	assign in_top  = in_dec[ADDR_W-1:0];
	assign out_top = out_dec[ADDR_W-1:0];
	assign cap_ext = CMP_W'(capacity);
	assign eff_cap = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
	assign fill    = CMP_W'(in_cnt_q) + CMP_W'(out_cnt_q);

	// Input stack memory: push writes, a transfer step reads the top.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			in_mem[in_cnt_q[ADDR_W-1:0]] <= val_q;
		end
		if (ctl.move) begin
			in_rd_q <= in_mem[in_top];
		end
	end

	// Output stack memory: the transferred entry lands in the cycle after its read.
	always_ff @(posedge clk) begin
		if (mv_pend_q) begin
			out_mem[out_cnt_q[ADDR_W-1:0]] <= in_rd_q;
		end
		if (ctl.pop_rd) begin
			out_rd_q <= out_mem[out_top];
		end
	end

	// Counters and transfer pending flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
			mv_pend_q <= 1'b0;
		end else begin
			mv_pend_q <= ctl.move;
			if (ctl.push) begin
				in_cnt_q <= in_cnt_q + CNT_W'(1);
			end else if (ctl.move) begin
				in_cnt_q <= in_dec;
			end
			if (mv_pend_q) begin
				out_cnt_q <= out_cnt_q + CNT_W'(1);
			end else if (ctl.pop_rd && op_q == OP_DEQ) begin
				out_cnt_q <= out_dec;
			end
		end
	end

	// Result register: holds a finished item until the consumer takes it.
	assign slot_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.emit && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit && slot_free) begin
			rsp_q.status     <= ctl.status;
			rsp_q.read_value <= ctl.sel_rd ? rd_trim : 32'd0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Flags for the sequencer.
	always_comb begin
		flags.accept    = accept;
		flags.opcode    = op_q;
		flags.full      = (fill >= eff_cap) || (in_cnt_q >= CNT_W'(DEPTH));
		flags.empty     = (in_cnt_q == '0) && (out_cnt_q == '0);
		flags.out_nz    = (out_cnt_q != '0);
		flags.in_more   = (in_cnt_q > CNT_W'(1));
		flags.slot_free = slot_free;
	end

`ifndef SYNTHESIS
	// Both stacks together never hold more than the memory depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= CMP_W'(DEPTH))
		else $error("queue fill exceeds depth");

	// A push only happens with room on the input stack.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> (in_cnt_q < CNT_W'(DEPTH)))
		else $error("push into a full input stack");

	// A transfer step only reads a nonempty input stack.
	a_move_src: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.move |-> (in_cnt_q != '0))
		else $error("transfer from an empty input stack");

	// The top read never overlaps a pending transfer write and never sees
	// an empty output stack.
	a_pop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop_rd |-> (!mv_pend_q && out_cnt_q != '0))
		else $error("output stack read while a transfer is in flight or empty");

	// A transfer always finishes by landing its entry on the output stack,
	// which advances the output count when the pending entry is written.
	a_move_lands: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.move |-> ##2 (out_cnt_q == $past(out_cnt_q) + CNT_W'(1)))
		else $error("transfer write did not advance the output stack");
`endif

endmodule

// ----- bench/two_stack_queue_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-stack queue core testbench
// Drives enqueue, dequeue, peek and no-op items through the command channel
// with random gaps and result stalls. Each accepted item updates a software
// copy of both stacks, and the result it should produce is compared with the
// result that the core returns. The capacity register is swept through its
// extremes and through random settings between phases.
// ----------------------------------------------------------------------------
module two_stack_queue_core_test import tsq_pkg::*;;

	localparam int QUEUE_DEPTH = 16;
	localparam int PHASES      = 17;
	localparam int PHASE_ITEMS = 100;

	// Software copy of the two stacks and the results still owed by the core.
	class two_stack_tracker;
		logic [31:0]      in_stack [QUEUE_DEPTH];
		logic [31:0]      out_stack [QUEUE_DEPTH];
		int               in_count;
		int               out_count;
		logic [CAP_W-1:0] capacity;
		rsp_t             owed_replies [$];
		int               errors;

		function new();
			in_count  = 0;
			out_count = 0;
			capacity  = CAP_RESET;
			errors    = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] value);
			capacity = value;
		endfunction

		// Print one mismatch.
		function void flag(string what, logic [31:0] want, logic [31:0] got);
			errors++;
			$display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
		endfunction

		// Apply one accepted item to the stacks and record the result it owes.
		function void take_command(cmd_t c);
			rsp_t r;
			int   limit;
			r.status     = ST_OK;
			r.read_value = '0;
			limit = (capacity > QUEUE_DEPTH) ? QUEUE_DEPTH : capacity;
			case (c.opcode)
				OP_ENQ: begin
					if (in_count + out_count >= limit || in_count >= QUEUE_DEPTH) begin
						r.status = ST_OVERFLOW;
					end else begin
						in_stack[in_count] = c.push_value;
						in_count++;
					end
				end
				OP_DEQ, OP_PEEK: begin
					if (in_count == 0 && out_count == 0) begin
						r.status = ST_UNDERFLOW;
					end else begin
						// An empty output stack is refilled from the input stack,
						// which reverses the order.
						if (out_count == 0) begin
							while (in_count != 0 && out_count < QUEUE_DEPTH) begin
								in_count--;
								out_stack[out_count] = in_stack[in_count];
								out_count++;
							end
						end
						if (out_count == 0) begin
							r.status = ST_UNDERFLOW;
						end else begin
							r.read_value = out_stack[out_count - 1];
							if (c.opcode == OP_DEQ)
								out_count--;
						end
					end
				end
				default: begin
				end
			endcase
			owed_replies.push_back(r);
		endfunction

		// Compare one result from the core with the oldest owed result.
		function void match_reply(rsp_t got);
			rsp_t want;
			if (owed_replies.size() == 0) begin
				flag("unrequested result", '0, {got.status, got.read_value[29:0]});
				return;
			end
			want = owed_replies.pop_front();
			if (got.status !== want.status)
				flag("status", 32'(want.status), 32'(got.status));
			if (got.read_value !== want.read_value)
				flag("read_value", want.read_value, got.read_value);
		endfunction
	endclass

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             cmd_valid = 1'b0;
	logic             cmd_stall;
	cmd_t             cmd       = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b1;
	rsp_t             rsp;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_data  = '0;

	two_stack_tracker queue_state = new();
	bit               idle_on = 1'b1;

	two_stack_queue_core #(
		.DEPTH(QUEUE_DEPTH),
		.DATA_WIDTH(32)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Free-running 2 ns clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case the core hangs.
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Wait length before an item on either side; zero while idle gaps are switched off.
	function automatic int draw_gap();
		return idle_on ? $urandom_range(0, 6) : 0;
	endfunction

	// Random push value with the sign extremes mixed in.
	function automatic logic [31:0] draw_value();
		case ($urandom_range(0, 15))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Present one item and hold it until the core takes it.
	task automatic send_cmd(logic [1:0] op, logic [31:0] value);
		int   gap;
		cmd_t c;
		gap          = draw_gap();
		c.opcode     = op;
		c.push_value = value;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		queue_state.take_command(c);
	endtask

	// Stop sending and wait until every owed result has come back.
	task automatic drain_replies();
		cmd_valid <= 1'b0;
		while (queue_state.owed_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the capacity register; only called while the core is idle.
	task automatic write_capacity(logic [CAP_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		queue_state.set_capacity(value);
	endtask

	// Result side: random stalls before each item, then take it.
	initial begin
		int gap;
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (rsp_valid !== 1'b1);
			queue_state.match_reply(rsp);
		end
	end

	// Main sequence: reset, directed items, random phases, final check.
	initial begin
		int               roll;
		int               enq_weight;
		logic [1:0]       op;
		logic [CAP_W-1:0] cap;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue on both read operations, and a no-op.
		send_cmd(OP_PEEK, draw_value());
		send_cmd(OP_DEQ, draw_value());
		send_cmd(OP_NOP, $urandom);

		// Sign extremes through both stacks, with a refill in between.
		send_cmd(OP_ENQ, 32'h7fff_ffff);
		send_cmd(OP_ENQ, 32'h8000_0000);
		send_cmd(OP_PEEK, '0);
		send_cmd(OP_ENQ, 32'h0000_0000);
		send_cmd(OP_ENQ, 32'hffff_ffff);
		send_cmd(OP_DEQ, '0);
		send_cmd(OP_DEQ, '0);
		send_cmd(OP_DEQ, '0);
		send_cmd(OP_PEEK, '0);
		send_cmd(OP_DEQ, '0);
		send_cmd(OP_DEQ, '0);
		drain_replies();

		// Small capacity reached, then lowered below the current fill.
		write_capacity(5'd2);
		send_cmd(OP_ENQ, $urandom);
		send_cmd(OP_ENQ, $urandom);
		send_cmd(OP_ENQ, $urandom);
		drain_replies();
		write_capacity(5'd1);
		send_cmd(OP_ENQ, $urandom);
		send_cmd(OP_DEQ, '0);
		send_cmd(OP_ENQ, $urandom);
		send_cmd(OP_DEQ, '0);
		drain_replies();

		// Zero capacity refuses every enqueue.
		write_capacity(5'd0);
		send_cmd(OP_ENQ, $urandom);
		drain_replies();

		// Random phases, alternating fill-heavy and drain-heavy mixes.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       cap = 5'd31;
				1:       cap = 5'd16;
				2:       cap = 5'd1;
				3:       cap = 5'd0;
				4:       cap = 5'd17;
				default: cap = 5'($urandom_range(0, 31));
			endcase
			write_capacity(cap);
			idle_on    = (p % 4 != 3);
			enq_weight = (p % 2 == 0) ? $urandom_range(55, 75) : $urandom_range(25, 45);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < enq_weight)
					op = OP_ENQ;
				else if (roll < 93)
					op = ($urandom_range(0, 2) == 0) ? OP_PEEK : OP_DEQ;
				else
					op = OP_NOP;
				send_cmd(op, draw_value());
				// Hold off mid-phase until the core has answered everything.
				if (p == 5 && n == PHASE_ITEMS / 2)
					drain_replies();
			end
			drain_replies();
		end

		idle_on = 1'b0;
		repeat (20) @(posedge clk);
		if (queue_state.owed_replies.size() != 0)
			queue_state.flag("missing results", '0, queue_state.owed_replies.size());

		if (queue_state.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
